[src/nnis_pkg.sv]
package nnis_pkg;

  // Default sizes of the frame store and the scaled image
  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned MAX_DST_SIDE   = 1024;
  localparam int unsigned PAD_DOTS       = 4;

  // Fixed field and register widths
  localparam int unsigned SRC_SIZE_W = 9;
  localparam int unsigned DST_SIZE_W = 11;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned X_W        = 11;
  localparam int unsigned Y_W        = 10;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned SIZE_RESET = 256;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_FETCH = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [X_W-1:0]     x_pos;
    logic [Y_W-1:0]     y_pos;
    logic [PIX_W-1:0]   pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             status;
  } rsp_t;

  // Zero reads as one, anything above the limit reads as the limit
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int unsigned mx);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (32'(v) > mx) begin
      r = CFG_W'(mx);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[src/nnis_if.sv]
interface nnis_req_if;
  logic          valid;
  logic          ready;
  nnis_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface nnis_rsp_if;
  logic          valid;
  logic          ready;
  nnis_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/nearest_neighbor_image_scaler.sv]
// Channel   Dir  Word                                    Accepted when
// req_i     in   req_type, x_pos, y_pos, pixel_in        req_i.valid & req_i.ready
// rsp_o     out  pixel_out, status                       rsp_o.valid & rsp_o.ready
// cfg       in   cfg_idx_i, cfg_data_i                   cfg_we_i
//
// One word per clock in and out; each word passes through stage 1, the product stage,
// the bit-per-stage divider, the address stage and the frame read register.
// Loads and fetches reach the frame store at the same stage, so a fetch sees every
// earlier load. The whole pipeline holds while a result waits at rsp_o.
// Reset clears the valid bits and sets the four sizes to 256; the frame store is
// not cleared.
module nearest_neighbor_image_scaler #(
  parameter int unsigned MAX_SRC_WIDTH  = nnis_pkg::MAX_SRC_WIDTH,
  parameter int unsigned MAX_SRC_HEIGHT = nnis_pkg::MAX_SRC_HEIGHT,
  parameter int unsigned MAX_DST_SIDE   = nnis_pkg::MAX_DST_SIDE,
  parameter int unsigned PAD_DOTS       = nnis_pkg::PAD_DOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nnis_req_if.sink                      req_i,
  nnis_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  nnis_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [nnis_pkg::CFG_W-1:0]    cfg_data_i
);

  import nnis_pkg::*;

  localparam int unsigned SIDE_PAD = PAD_DOTS / 2;
  localparam int unsigned CW       = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned RW       = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned QW       = (CW > RW) ? CW : RW;
  localparam int unsigned PROD_W   = X_W + SRC_SIZE_W;
  localparam int unsigned DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW       = $clog2(DEPTH);

  localparam logic [SRC_SIZE_W-1:0] SW_RST =
    SRC_SIZE_W'(clamp_size(CFG_W'(SIZE_RESET), MAX_SRC_WIDTH));
  localparam logic [SRC_SIZE_W-1:0] SH_RST =
    SRC_SIZE_W'(clamp_size(CFG_W'(SIZE_RESET), MAX_SRC_HEIGHT));
  localparam logic [DST_SIZE_W-1:0] DS_RST =
    DST_SIZE_W'(clamp_size(CFG_W'(SIZE_RESET), MAX_DST_SIDE));

  typedef struct packed {
    req_type_e        req_type;
    logic             bad;
    logic [X_W-1:0]   col;
    logic [Y_W-1:0]   row;
    logic [PIX_W-1:0] pix;
  } s1_t;

  typedef struct packed {
    req_type_e        req_type;
    logic             bad;
    logic [CW-1:0]    lcol;
    logic [RW-1:0]    lrow;
    logic [PIX_W-1:0] pix;
  } sb_t;

  // Size registers hold the already clamped values
  logic [SRC_SIZE_W-1:0] sw_q, sh_q;
  logic [DST_SIZE_W-1:0] dw_q, dh_q;

  logic                  adv;
  logic                  s1_vld_q, s2_vld_q, sa_vld_q, out_vld_q;
  logic [QW-1:0]         dv_vld_q;
  s1_t                   s1_d, s1_q;
  sb_t                   s2_sb_q, sa_sb_q;
  sb_t                   dv_sb_q [QW];
  logic [PROD_W-1:0]     prodc_q, prodr_q;
  logic [QW-1:0]         quot_c, quot_r;
  logic [AW-1:0]         addr_d, addr_q;
  logic                  zero_q, status_q;
  logic [PIX_W-1:0]      rdata;

  logic [X_W:0]          x_lim;
  logic [X_W-1:0]        x_sh;
  logic [DST_SIZE_W-1:0] dw_last;
  logic [CW-1:0]         col_sel;
  logic [RW-1:0]         row_sel;
  logic                  mem_we;

  assign adv         = !out_vld_q || rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= SW_RST;
      sh_q <= SH_RST;
      dw_q <= DS_RST;
      dh_q <= DS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH:  sw_q <= SRC_SIZE_W'(clamp_size(
                                  CFG_W'(cfg_data_i[SRC_SIZE_W-1:0]), MAX_SRC_WIDTH));
        CFG_SRC_HEIGHT: sh_q <= SRC_SIZE_W'(clamp_size(
                                  CFG_W'(cfg_data_i[SRC_SIZE_W-1:0]), MAX_SRC_HEIGHT));
        CFG_DST_WIDTH:  dw_q <= DST_SIZE_W'(clamp_size(cfg_data_i, MAX_DST_SIDE));
        CFG_DST_HEIGHT: dh_q <= DST_SIZE_W'(clamp_size(cfg_data_i, MAX_DST_SIDE));
        default: ;
      endcase
    end
  end

  // Stage 1: range check and column clamp
  assign x_lim   = (X_W+1)'(dw_q) + (X_W+1)'(2 * SIDE_PAD);
  assign x_sh    = (32'(req_i.data.x_pos) < SIDE_PAD) ? '0
                 : req_i.data.x_pos - X_W'(SIDE_PAD);
  assign dw_last = dw_q - DST_SIZE_W'(1);

  always_comb begin
    s1_d.req_type = req_i.data.req_type;
    s1_d.row      = req_i.data.y_pos;
    s1_d.pix      = req_i.data.pixel_in;
    if (req_i.data.req_type == REQ_FETCH) begin
      s1_d.bad = ((X_W+1)'(req_i.data.x_pos) >= x_lim)
              || (DST_SIZE_W'(req_i.data.y_pos) >= dh_q);
      s1_d.col = (x_sh > X_W'(dw_last)) ? X_W'(dw_last) : x_sh;
    end else begin
      s1_d.bad = (req_i.data.x_pos >= X_W'(sw_q))
              || (req_i.data.y_pos >= Y_W'(sh_q));
      s1_d.col = req_i.data.x_pos;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      sa_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= req_i.valid;
      s2_vld_q  <= s1_vld_q;
      dv_vld_q  <= {dv_vld_q[QW-2:0], s2_vld_q} >> 0;
      sa_vld_q  <= dv_vld_q[QW-1];
      out_vld_q <= sa_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q             <= s1_d;
      prodc_q          <= PROD_W'(s1_q.col) * PROD_W'(sw_q);
      prodr_q          <= PROD_W'(s1_q.row) * PROD_W'(sh_q);
      s2_sb_q.req_type <= s1_q.req_type;
      s2_sb_q.bad      <= s1_q.bad;
      s2_sb_q.lcol     <= CW'(s1_q.col);
      s2_sb_q.lrow     <= RW'(s1_q.row);
      s2_sb_q.pix      <= s1_q.pix;
      dv_sb_q[0]       <= s2_sb_q;
      for (int i = 1; i < QW; i++) begin
        dv_sb_q[i] <= dv_sb_q[i-1];
      end
      sa_sb_q          <= dv_sb_q[QW-1];
      addr_q           <= addr_d;
      zero_q           <= (sa_sb_q.req_type == REQ_LOAD) || sa_sb_q.bad;
      status_q         <= sa_sb_q.bad;
    end
  end

  nnis_div #(
    .NUM_W (PROD_W),
    .DEN_W (DST_SIZE_W),
    .QW    (QW)
  ) u_div_col (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (prodc_q),
    .den_i  (dw_q),
    .quot_o (quot_c)
  );

  nnis_div #(
    .NUM_W (PROD_W),
    .DEN_W (DST_SIZE_W),
    .QW    (QW)
  ) u_div_row (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (prodr_q),
    .den_i  (dh_q),
    .quot_o (quot_r)
  );

  // Address stage: loads keep their own place, fetches take the quotients
  assign col_sel = (dv_sb_q[QW-1].req_type == REQ_FETCH) ? CW'(quot_c) : dv_sb_q[QW-1].lcol;
  assign row_sel = (dv_sb_q[QW-1].req_type == REQ_FETCH) ? RW'(quot_r) : dv_sb_q[QW-1].lrow;
  assign addr_d  = AW'(32'(row_sel) * MAX_SRC_WIDTH + 32'(col_sel));

  assign mem_we = adv && sa_vld_q && (sa_sb_q.req_type == REQ_LOAD) && !sa_sb_q.bad;

  nnis_frame #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIX_W)
  ) u_frame (
    .clk_i   (clk_i),
    .en_i    (adv),
    .we_i    (mem_we),
    .addr_i  (addr_q),
    .wdata_i (sa_sb_q.pix),
    .rdata_o (rdata)
  );

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.data.pixel_out = zero_q ? '0 : rdata;
  assign rsp_o.data.status    = status_q;

endmodule

[src/nnis_div.sv]
module nnis_div #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 11,
  parameter int unsigned QW    = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QW-1:0]    quot_o
);

  // Restoring division, one quotient bit per stage; the quotient must fit QW bits
  localparam int unsigned CMP_W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [CMP_W-1:0] rem_q  [QW];
  logic [QW-1:0]    quot_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int unsigned B = QW - 1 - i;

    logic [CMP_W-1:0] rem_in;
    logic [QW-1:0]    q_in;
    logic [CMP_W-1:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = CMP_W'(num_i);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign q_in   = quot_q[i-1];
    end

    assign trial = CMP_W'(den_i) << B;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (rem_in - trial) : rem_in;
        quot_q[i] <= q_in | (ge ? (QW'(1) << B) : QW'(0));
      end
    end
  end

  assign quot_o = quot_q[QW-1];

endmodule

[src/nnis_frame.sv]
module nnis_frame #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/nnis_chk.sv]
module nnis_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [nnis_pkg::PIX_W-1:0] pixel_out_i,
  input logic                       status_i
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_out_i) && $stable(status_i))
    else $error("result changed while stalled");

  // With the output free the pipeline always takes a word
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready while output empty");

  // A stalled output holds the whole pipeline
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // A rejected word carries no pixel
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> pixel_out_i == '0)
    else $error("pixel on a failed word");

endmodule

bind nearest_neighbor_image_scaler nnis_chk u_nnis_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .pixel_out_i (rsp_o.data.pixel_out),
  .status_i    (rsp_o.data.status)
);

[tb/nearest_neighbor_image_scaler_tb.sv]
module nearest_neighbor_image_scaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnis_pkg::*;

  localparam int unsigned SIDE_PAD     = PAD_DOTS / 2;
  localparam int unsigned FRAME_SIZE   = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned PIPE_CYCLES  = 16;
  localparam int unsigned CHOKE_CYCLES = 400;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned CHUNK_WORDS  = 25;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_idx_e         cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  nnis_req_if req_if ();
  nnis_rsp_if rsp_if ();

  nearest_neighbor_image_scaler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sizes as last written to the block
  logic [SRC_SIZE_W-1:0] src_w_reg = SRC_SIZE_W'(SIZE_RESET);
  logic [SRC_SIZE_W-1:0] src_h_reg = SRC_SIZE_W'(SIZE_RESET);
  logic [DST_SIZE_W-1:0] dst_w_reg = DST_SIZE_W'(SIZE_RESET);
  logic [DST_SIZE_W-1:0] dst_h_reg = DST_SIZE_W'(SIZE_RESET);

  logic [PIX_W-1:0] frame_pixels [FRAME_SIZE];
  bit               frame_written [FRAME_SIZE];

  req_t pending_words[$];
  rsp_t expected_pixels[$];
  rsp_t want_rsp;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned choke_asks = 0;
  int unsigned choke_seen = 0;
  int unsigned choke_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_e    stall_mode = RX_OPEN;
  logic        ready_next;

  int unsigned mismatches = 0;
  int unsigned loads_sent = 0;
  int unsigned fetches_sent = 0;
  int unsigned results_seen = 0;
  int unsigned rejects_seen = 0;
  int unsigned settings_used = 0;

  function automatic int unsigned fit_size(int unsigned v, int unsigned mx);
    if (v == 0) begin
      return 1;
    end else if (v > mx) begin
      return mx;
    end
    return v;
  endfunction

  // Frame address a word touches, or -1 when its coordinates are out of range
  function automatic int frame_index(req_t w);
    int unsigned sw, sh, dw, dh, col, scol, srow;
    sw = fit_size(src_w_reg, MAX_SRC_WIDTH);
    sh = fit_size(src_h_reg, MAX_SRC_HEIGHT);
    dw = fit_size(dst_w_reg, MAX_DST_SIDE);
    dh = fit_size(dst_h_reg, MAX_DST_SIDE);
    if (w.req_type == REQ_LOAD) begin
      if (w.x_pos >= sw || w.y_pos >= sh) begin
        return -1;
      end
      return w.y_pos * MAX_SRC_WIDTH + w.x_pos;
    end
    if (w.x_pos >= dw + 2 * SIDE_PAD || w.y_pos >= dh) begin
      return -1;
    end
    // padding columns repeat the edge columns
    if (w.x_pos < SIDE_PAD) begin
      col = 0;
    end else begin
      col = w.x_pos - SIDE_PAD;
    end
    if (col > dw - 1) begin
      col = dw - 1;
    end
    scol = col * sw / dw;
    srow = w.y_pos * sh / dh;
    return srow * MAX_SRC_WIDTH + scol;
  endfunction

  function automatic rsp_t scale_pixel(req_t w);
    rsp_t r;
    int   idx;
    idx = frame_index(w);
    r.pixel_out = '0;
    r.status = (idx < 0);
    if (idx >= 0) begin
      if (w.req_type == REQ_LOAD) begin
        frame_pixels[idx] = w.pixel_in;
      end else begin
        r.pixel_out = frame_pixels[idx];
      end
    end
    return r;
  endfunction

  function automatic req_t make_word(req_type_e k, int unsigned x, int unsigned y,
                                     logic [PIX_W-1:0] p);
    req_t w;
    w.req_type = k;
    w.x_pos    = X_W'(x);
    w.y_pos    = Y_W'(y);
    w.pixel_in = p;
    return w;
  endfunction

  task automatic queue_word(req_t w);
    int   idx;
    req_t pre;
    idx = frame_index(w);
    if (w.req_type == REQ_FETCH && idx >= 0 && !frame_written[idx]) begin
      // load the source pixel first so that no fetch reads an empty entry
      pre = make_word(REQ_LOAD, idx % MAX_SRC_WIDTH, idx / MAX_SRC_WIDTH, PIX_W'($urandom));
      pending_words.push_back(pre);
      frame_written[idx] = 1'b1;
    end
    if (w.req_type == REQ_LOAD && idx >= 0) begin
      frame_written[idx] = 1'b1;
    end
    pending_words.push_back(w);
  endtask

  task automatic queue_random_word();
    int unsigned sw, sh, dw, dh, pick;
    sw = fit_size(src_w_reg, MAX_SRC_WIDTH);
    sh = fit_size(src_h_reg, MAX_SRC_HEIGHT);
    dw = fit_size(dst_w_reg, MAX_DST_SIDE);
    dh = fit_size(dst_h_reg, MAX_DST_SIDE);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      queue_word(make_word(REQ_LOAD, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                           PIX_W'($urandom)));
    end else if (pick < 85) begin
      queue_word(make_word(REQ_FETCH, $urandom_range(0, dw + 2 * SIDE_PAD - 1),
                           $urandom_range(0, dh - 1), PIX_W'($urandom)));
    end else if (pick < 93) begin
      queue_word(make_word(req_type_e'($urandom_range(0, 1)), $urandom_range(0, 2047),
                           $urandom_range(0, 1023), PIX_W'($urandom)));
    end else if (pick < 96) begin
      if ($urandom_range(0, 1) == 0) begin
        queue_word(make_word(REQ_LOAD, sw, $urandom_range(0, sh - 1), PIX_W'($urandom)));
      end else begin
        queue_word(make_word(REQ_LOAD, $urandom_range(0, sw - 1), sh, PIX_W'($urandom)));
      end
    end else begin
      // a row of 1024 cannot be named in the y field, so step past the width instead
      if ($urandom_range(0, 1) == 0 || dh > 1023) begin
        queue_word(make_word(REQ_FETCH, dw + 2 * SIDE_PAD, $urandom_range(0, dh - 1),
                             PIX_W'($urandom)));
      end else begin
        queue_word(make_word(REQ_FETCH, $urandom_range(0, dw + 2 * SIDE_PAD - 1), dh,
                             PIX_W'($urandom)));
      end
    end
  endtask

  task automatic write_size(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_SRC_WIDTH:  src_w_reg = val[SRC_SIZE_W-1:0];
      CFG_SRC_HEIGHT: src_h_reg = val[SRC_SIZE_W-1:0];
      CFG_DST_WIDTH:  dst_w_reg = val[DST_SIZE_W-1:0];
      default:        dst_h_reg = val[DST_SIZE_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                           logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh);
    write_size(CFG_SRC_WIDTH, sw);
    write_size(CFG_SRC_HEIGHT, sh);
    write_size(CFG_DST_WIDTH, dw);
    write_size(CFG_DST_HEIGHT, dh);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of words with random gaps, holding each word until taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      if (req_if.valid) begin
        if (pending_words[0].req_type == REQ_LOAD) begin
          loads_sent++;
        end else begin
          fetches_sent++;
        end
        expected_pixels.push_back(scale_pixel(pending_words.pop_front()));
        if (burst_left > 0) begin
          burst_left--;
        end
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.data  <= pending_words[0];
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result word and stall on a pattern of its own
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with nothing expected: pixel_out %h status %0d", $time,
                   rsp_if.data.pixel_out, rsp_if.data.status);
          mismatches++;
        end else begin
          want_rsp = expected_pixels.pop_front();
          if (rsp_if.data.pixel_out !== want_rsp.pixel_out) begin
            $display("%0t: pixel_out expected %h got %h", $time, want_rsp.pixel_out,
                     rsp_if.data.pixel_out);
            mismatches++;
          end
          if (rsp_if.data.status !== want_rsp.status) begin
            $display("%0t: status expected %0d got %0d", $time, want_rsp.status,
                     rsp_if.data.status);
            mismatches++;
          end
          results_seen++;
          if (want_rsp.status) begin
            rejects_seen++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
        stall_mode = rx_mode_e'($urandom_range(0, 3));
      end
      if (choke_asks != choke_seen) begin
        choke_seen = choke_asks;
        choke_left = CHOKE_CYCLES;
      end
      if (choke_left > 0) begin
        choke_left--;
        ready_next = 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:   ready_next = 1'b1;
          RX_COIN:   ready_next = ($urandom_range(0, 1) == 1);
          RX_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:   ready_next = (rx_cycle % 16) < 11;
        endcase
      end
      rsp_if.ready <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("nearest_neighbor_image_scaler_tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned c;
    rst_ni = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_SRC_WIDTH;
    cfg_data_i   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners and edges at the reset sizes
    queue_word(make_word(REQ_LOAD, 0, 0, 16'hFFFF));
    queue_word(make_word(REQ_LOAD, 255, 255, 16'h0000));
    queue_word(make_word(REQ_LOAD, 255, 0, 16'h1234));
    queue_word(make_word(REQ_LOAD, 0, 255, 16'h8001));
    queue_word(make_word(REQ_LOAD, 256, 0, 16'hAAAA));
    queue_word(make_word(REQ_LOAD, 0, 256, 16'h5555));
    queue_word(make_word(REQ_LOAD, 2047, 1023, 16'hFFFF));
    queue_word(make_word(REQ_FETCH, 0, 0, 16'h0000));
    queue_word(make_word(REQ_FETCH, 1, 0, 16'hFFFF));
    queue_word(make_word(REQ_FETCH, 2, 0, 16'h0000));
    queue_word(make_word(REQ_FETCH, 2, 255, 16'h0000));
    queue_word(make_word(REQ_FETCH, 257, 255, 16'h0000));
    queue_word(make_word(REQ_FETCH, 259, 255, 16'h0000));
    queue_word(make_word(REQ_FETCH, 258, 0, 16'h0000));
    queue_word(make_word(REQ_FETCH, 260, 0, 16'h0000));
    queue_word(make_word(REQ_FETCH, 2, 256, 16'h0000));
    queue_word(make_word(REQ_FETCH, 2047, 1023, 16'hFFFF));
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_sizes(0, 0, 0, 0);
        1:       set_sizes(11'h7FF, 11'h1FF, 11'h7FF, 1500);
        2:       set_sizes(256, 256, 1024, 1024);
        3:       set_sizes(256, 256, 1, 1);
        4:       set_sizes(1, 256, 1024, 3);
        default: set_sizes(CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(1, 256)),
                           CFG_W'($urandom_range(1, 1024)), CFG_W'($urandom_range(1, 1024)));
      endcase
      // hold the receiver off long enough to back the block up into its input
      if (p == 2) begin
        choke_asks++;
      end
      for (c = 0; c < 3; c++) begin
        repeat (CHUNK_WORDS) queue_random_word();
        if (c == 1) begin
          wait_idle();
        end
      end
      wait_idle();
    end

    $display("covered %0d loads and %0d fetches, %0d results checked, %0d rejected",
             loads_sent, fetches_sent, results_seen, rejects_seen);
    $display("across %0d size settings, including zero and over-range sizes",
             settings_used);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_pixels.size());
      mismatches += expected_pixels.size();
    end
    if (mismatches == 0) begin
      $display("nearest_neighbor_image_scaler_tb: clean");
    end else begin
      $display("nearest_neighbor_image_scaler_tb: errors");
    end
    $finish;
  end

endmodule
